// File: design/mvsm_pkg.sv
package mvsm_pkg;

  localparam int VOICES       = 16;
  localparam int CHANNELS     = 2;
  localparam int SAMPLE_WORDS = 65536;

  localparam int WORD_W  = 16;
  localparam int VID_W   = 4;
  localparam int MASK_W  = 16;
  localparam int VIDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int SADDR_W = $clog2(SAMPLE_WORDS);
  localparam int PROD_W  = 2 * WORD_W + 1;
  localparam int ACC_W   = PROD_W + VIDX_W + 1;

  typedef enum logic [1:0] {
    MODE_LOAD   = 2'd0,
    MODE_PLAY   = 2'd1,
    MODE_STOP   = 2'd2,
    MODE_RENDER = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_VRD,
    S_VCHK,
    S_CH0,
    S_CH1,
    S_ACC,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [WORD_W-1:0] start;
    logic [WORD_W-1:0] length;
    logic [WORD_W-1:0] position;
    logic [WORD_W-1:0] volume;
  } voice_t;

  typedef struct packed {
    logic clear;
    logic mul;
    logic acc;
    logic ch;
  } mac_ctrl_t;

endpackage

// File: design/multi_voice_sample_mixer_unit.sv
// Channel   Direction  Signals
// request   in         start_i, busy_o, mode_i, mem_address_i, sample_value_i,
//                      length_frames_i, gain_i, voice_select_i
// result    out        done_o, voice_id_o, play_ok_o, mix_left_o, mix_right_o,
//                      finished_mask_o
//
// Load, play and stop strobe their result on the next cycle.
// Render walks the voice table: a free voice is skipped, a voice that ends is
// dropped, and a playing voice takes a voice read, two sample reads on the one
// sample memory port, a multiply and a write back; then the mix strobes.
// Reset clears the active bits and control; memories are not cleared.
// The result strobe cannot be stalled; busy_o is high only during a render.
module multi_voice_sample_mixer_unit import mvsm_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [1:0]               mode_i,
  input  logic [WORD_W-1:0]        mem_address_i,
  input  logic signed [WORD_W-1:0] sample_value_i,
  input  logic [WORD_W-1:0]        length_frames_i,
  input  logic [WORD_W-1:0]        gain_i,
  input  logic [VID_W-1:0]         voice_select_i,
  output logic                     done_o,
  output logic [VID_W-1:0]         voice_id_o,
  output logic                     play_ok_o,
  output logic signed [WORD_W-1:0] mix_left_o,
  output logic signed [WORD_W-1:0] mix_right_o,
  output logic [MASK_W-1:0]        finished_mask_o
);

  state_e              state_q, state_d;
  logic [VIDX_W-1:0]   v_q, v_d;
  logic [VOICES-1:0]   active_q;
  logic [VOICES-1:0]   fin_q;
  logic                done_q;
  logic [WORD_W-1:0]   addr_q, addr_d;
  logic                rng_q, rng_d;
  logic [VID_W-1:0]    vid_q;
  logic                ok_q;
  logic signed [WORD_W-1:0] left_q, right_q;

  mode_e               mode;
  logic                accept;
  logic                last_voice;

  logic                free_found;
  logic [VIDX_W-1:0]   free_idx;

  logic                vram_we, vram_re;
  logic [VIDX_W-1:0]   vram_waddr;
  voice_t              vram_wdata, entry;
  logic [$bits(voice_t)-1:0] vram_rdata;

  logic                sram_we, sram_re;
  logic [WORD_W-1:0]   sram_raddr;
  logic [WORD_W-1:0]   sram_rdata;
  logic signed [WORD_W-1:0] sample;

  mac_ctrl_t           mac_ctrl;
  logic signed [WORD_W-1:0] mac_left, mac_right;

  logic                pos_done;
  logic [WORD_W-1:0]   first_addr;

  assign mode       = mode_e'(mode_i);
  assign accept     = start_i && (state_q == S_IDLE);
  assign last_voice = (v_q == VIDX_W'(VOICES - 1));
  assign entry      = voice_t'(vram_rdata);
  assign pos_done   = (entry.position >= entry.length);
  assign first_addr = WORD_W'(entry.start + WORD_W'(CHANNELS) * entry.position);
  assign sample     = rng_q ? $signed(sram_rdata) : '0;

  // lowest free voice
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int v = VOICES - 1; v >= 0; v--) begin
      if (!active_q[v]) begin
        free_found = 1'b1;
        free_idx   = VIDX_W'(v);
      end
    end
  end

  mvsm_ram #(
    .WIDTH ($bits(voice_t)),
    .DEPTH (VOICES)
  ) u_voice_ram (
    .clk_i   (clk_i),
    .we_i    (vram_we),
    .waddr_i (vram_waddr),
    .wdata_i (vram_wdata),
    .re_i    (vram_re),
    .raddr_i (v_q),
    .rdata_o (vram_rdata)
  );

  mvsm_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SAMPLE_WORDS)
  ) u_sample_ram (
    .clk_i   (clk_i),
    .we_i    (sram_we),
    .waddr_i (mem_address_i[SADDR_W-1:0]),
    .wdata_i (sample_value_i),
    .re_i    (sram_re),
    .raddr_i (sram_raddr[SADDR_W-1:0]),
    .rdata_o (sram_rdata)
  );

  mvsm_mac u_mac (
    .clk_i    (clk_i),
    .ctrl_i   (mac_ctrl),
    .gain_i   (entry.volume),
    .sample_i (sample),
    .left_o   (mac_left),
    .right_o  (mac_right)
  );

  always_comb begin
    state_d    = state_q;
    v_d        = v_q;
    addr_d     = addr_q;
    rng_d      = rng_q;
    vram_we    = 1'b0;
    vram_re    = 1'b0;
    vram_waddr = v_q;
    vram_wdata = entry;
    sram_we    = 1'b0;
    sram_re    = 1'b0;
    sram_raddr = addr_q;
    mac_ctrl   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (mode)
            MODE_LOAD: begin
              sram_we = ({1'b0, mem_address_i} < (WORD_W + 1)'(SAMPLE_WORDS));
            end
            MODE_PLAY: begin
              vram_we    = free_found;
              vram_waddr = free_idx;
              vram_wdata = '{start: mem_address_i, length: length_frames_i,
                             position: '0, volume: gain_i};
            end
            MODE_STOP: begin
            end
            MODE_RENDER: begin
              mac_ctrl.clear = 1'b1;
              v_d            = '0;
              state_d        = S_VRD;
            end
            default: begin
            end
          endcase
        end
      end
      S_VRD: begin
        if (active_q[v_q]) begin
          vram_re = 1'b1;
          state_d = S_VCHK;
        end else if (last_voice) begin
          state_d = S_DONE;
        end else begin
          v_d = v_q + 1'b1;
        end
      end
      S_VCHK: begin
        if (pos_done) begin
          if (last_voice) begin
            state_d = S_DONE;
          end else begin
            v_d     = v_q + 1'b1;
            state_d = S_VRD;
          end
        end else begin
          sram_re    = 1'b1;
          sram_raddr = first_addr;
          addr_d     = first_addr;
          rng_d      = ({1'b0, first_addr} < (WORD_W + 1)'(SAMPLE_WORDS));
          state_d    = S_CH0;
        end
      end
      S_CH0: begin
        mac_ctrl.mul = 1'b1;
        if (CHANNELS > 1) begin
          sram_re    = 1'b1;
          sram_raddr = addr_q + 1'b1;
          rng_d      = ({1'b0, WORD_W'(addr_q + 1'b1)} < (WORD_W + 1)'(SAMPLE_WORDS));
          state_d    = S_CH1;
        end else begin
          state_d = S_ACC;
        end
      end
      S_CH1: begin
        mac_ctrl.acc = 1'b1;
        mac_ctrl.ch  = 1'b0;
        mac_ctrl.mul = 1'b1;
        state_d      = S_ACC;
      end
      S_ACC: begin
        mac_ctrl.acc        = 1'b1;
        mac_ctrl.ch         = (CHANNELS > 1);
        vram_we             = 1'b1;
        vram_wdata.position = entry.position + 1'b1;
        if (last_voice) begin
          state_d = S_DONE;
        end else begin
          v_d     = v_q + 1'b1;
          state_d = S_VRD;
        end
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      v_q      <= '0;
      active_q <= '0;
      fin_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      v_q     <= v_d;
      done_q  <= 1'b0;
      if (accept) begin
        // every request starts with an empty finished mask
        fin_q <= '0;
        unique case (mode)
          MODE_PLAY: begin
            if (free_found) begin
              active_q[free_idx] <= 1'b1;
            end
            done_q <= 1'b1;
          end
          MODE_STOP: begin
            for (int v = 0; v < VOICES; v++) begin
              if (voice_select_i == VID_W'(v)) begin
                active_q[v] <= 1'b0;
              end
            end
            done_q <= 1'b1;
          end
          MODE_RENDER: begin
          end
          default: begin
            done_q <= 1'b1;
          end
        endcase
      end
      // drop a voice that has played its whole length
      if (state_q == S_VCHK && pos_done) begin
        active_q[v_q] <= 1'b0;
        fin_q[v_q]    <= 1'b1;
      end
      if (state_q == S_DONE) begin
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    rng_q  <= rng_d;
    if (accept && mode != MODE_RENDER) begin
      vid_q   <= (mode == MODE_PLAY && free_found) ? VID_W'(free_idx) : '0;
      ok_q    <= (mode == MODE_PLAY) && free_found;
      left_q  <= '0;
      right_q <= '0;
    end else if (state_q == S_DONE) begin
      vid_q   <= '0;
      ok_q    <= 1'b0;
      left_q  <= mac_left;
      right_q <= mac_right;
    end
  end

  assign busy_o          = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign voice_id_o      = vid_q;
  assign play_ok_o       = ok_q;
  assign mix_left_o      = left_q;
  assign mix_right_o     = right_q;
  assign finished_mask_o = MASK_W'(fin_q);

endmodule

// File: design/mvsm_ram.sv
module mvsm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/mvsm_mac.sv
module mvsm_mac import mvsm_pkg::*; (
  input  logic                     clk_i,
  input  mac_ctrl_t                ctrl_i,
  input  logic [WORD_W-1:0]        gain_i,
  input  logic signed [WORD_W-1:0] sample_i,
  output logic signed [WORD_W-1:0] left_o,
  output logic signed [WORD_W-1:0] right_o
);

  localparam int Q_W = ACC_W - 12;

  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc0_q;
  logic signed [ACC_W-1:0]  acc1_q;

  // round half up by 12 bits, then clamp to 16 bits
  function automatic logic signed [WORD_W-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] x;
    logic signed [Q_W-1:0]   q;
    logic signed [Q_W-1:0]   max_v;
    logic signed [Q_W-1:0]   min_v;
    x     = acc + ACC_W'(2048);
    q     = x[ACC_W-1:12];
    max_v = Q_W'(32767);
    min_v = Q_W'(-32768);
    if (q > max_v) begin
      return WORD_W'(max_v);
    end else if (q < min_v) begin
      return WORD_W'(min_v);
    end
    return WORD_W'(q);
  endfunction

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      prod_q <= $signed({1'b0, gain_i}) * sample_i;
    end
    if (ctrl_i.clear) begin
      acc0_q <= '0;
      acc1_q <= '0;
    end else if (ctrl_i.acc) begin
      if (ctrl_i.ch) begin
        acc1_q <= acc1_q + ACC_W'(prod_q);
      end else begin
        acc0_q <= acc0_q + ACC_W'(prod_q);
      end
    end
  end

  assign left_o  = round_sat(acc0_q);
  assign right_o = (CHANNELS > 1) ? round_sat(acc1_q) : round_sat(acc0_q);

endmodule

// File: design/mvsm_checker.sv
module mvsm_checker import mvsm_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start_i,
  input logic                     busy_o,
  input logic [1:0]               mode_i,
  input logic                     done_o,
  input logic [VID_W-1:0]         voice_id_o,
  input logic                     play_ok_o,
  input logic signed [WORD_W-1:0] mix_left_o,
  input logic signed [WORD_W-1:0] mix_right_o,
  input logic [MASK_W-1:0]        finished_mask_o
);

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o)
    else $error("result strobe while a render is running");

  a_short_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && mode_i != MODE_RENDER) |=> done_o)
    else $error("load, play or stop gave no result on the next cycle");

  a_render_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && mode_i == MODE_RENDER) |=> (busy_o && !done_o))
    else $error("render request did not raise busy");

  a_no_alloc_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !play_ok_o) |-> (voice_id_o == '0))
    else $error("voice id without a successful play");

  a_play_no_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && play_ok_o) |->
      (finished_mask_o == '0 && mix_left_o == '0 && mix_right_o == '0))
    else $error("play result carries mix data");

endmodule

bind multi_voice_sample_mixer_unit mvsm_checker u_mvsm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .mode_i          (mode_i),
  .done_o          (done_o),
  .voice_id_o      (voice_id_o),
  .play_ok_o       (play_ok_o),
  .mix_left_o      (mix_left_o),
  .mix_right_o     (mix_right_o),
  .finished_mask_o (finished_mask_o)
);

// File: bench/multi_voice_sample_mixer_unit_tb.sv
module multi_voice_sample_mixer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mvsm_pkg::*;

  localparam int CYCLE_LIMIT     = 600000;
  localparam int TOTAL_REQUESTS  = 1050;
  localparam int DRAIN_CYCLES    = 100;
  localparam logic [15:0] WINDOW_BASE = 16'h4000;

  typedef struct {
    mode_e             mode;
    logic [15:0]       addr;
    logic [15:0]       sample;
    logic [15:0]       frames;
    logic [15:0]       gain;
    logic [VID_W-1:0]  sel;
  } mix_req_t;

  typedef struct {
    logic [VID_W-1:0]  voice_id;
    logic              play_ok;
    logic [15:0]       left;
    logic [15:0]       right;
    logic [MASK_W-1:0] finished;
  } mix_res_t;

  typedef struct {
    mix_req_t req;
    int       reps;
    bit       typed;
    mix_res_t want;
  } script_row_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     start_i;
  logic                     busy_o;
  logic [1:0]               mode_i;
  logic [WORD_W-1:0]        mem_address_i;
  logic signed [WORD_W-1:0] sample_value_i;
  logic [WORD_W-1:0]        length_frames_i;
  logic [WORD_W-1:0]        gain_i;
  logic [VID_W-1:0]         voice_select_i;
  logic                     done_o;
  logic [VID_W-1:0]         voice_id_o;
  logic                     play_ok_o;
  logic signed [WORD_W-1:0] mix_left_o;
  logic signed [WORD_W-1:0] mix_right_o;
  logic [MASK_W-1:0]        finished_mask_o;

  // predictor state
  logic                     voice_on [VOICES];
  logic [15:0]              v_start  [VOICES];
  logic [15:0]              v_len    [VOICES];
  logic [15:0]              v_pos    [VOICES];
  logic [15:0]              v_gain   [VOICES];
  logic signed [15:0]       sample_mem  [SAMPLE_WORDS];
  bit                       word_loaded [SAMPLE_WORDS];

  mix_res_t pending_mix_results[$];

  int mismatches, results_checked, cycle_count, burst_left, requests_sent;
  int loads_seen, plays_seen, plays_refused, stops_seen, renders_seen;
  int voices_ended, clipped_samples;

  multi_voice_sample_mixer_unit u_dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic mix_req_t mk_req(mode_e mode, logic [15:0] addr, logic [15:0] sample,
                                      logic [15:0] frames, logic [15:0] gain,
                                      logic [VID_W-1:0] sel);
    mix_req_t rq;
    rq.mode   = mode;
    rq.addr   = addr;
    rq.sample = sample;
    rq.frames = frames;
    rq.gain   = gain;
    rq.sel    = sel;
    return rq;
  endfunction

  function automatic mix_res_t mk_res(logic [VID_W-1:0] vid, logic ok, logic [15:0] left,
                                      logic [15:0] right, logic [MASK_W-1:0] fin);
    mix_res_t r;
    r.voice_id = vid;
    r.play_ok  = ok;
    r.left     = left;
    r.right    = right;
    r.finished = fin;
    return r;
  endfunction

  // Drop 12 fraction bits, rounding half up, then clip to 16 bits.
  function automatic logic [15:0] round_to_word(longint acc);
    longint q;
    q = (acc + 2048) >>> 12;
    if (q > 32767) begin
      q = 32767;
      clipped_samples++;
    end else if (q < -32768) begin
      q = -32768;
      clipped_samples++;
    end
    return q[15:0];
  endfunction

  function automatic mix_res_t predict_mix(mix_req_t rq);
    mix_res_t r;
    longint acc [2];
    logic [15:0] a;
    r = mk_res(0, 0, 0, 0, 0);
    acc[0] = 0;
    acc[1] = 0;
    case (rq.mode)
      MODE_LOAD: begin
        loads_seen++;
        if (int'(rq.addr) < SAMPLE_WORDS) begin
          sample_mem[rq.addr]  = rq.sample;
          word_loaded[rq.addr] = 1'b1;
        end
      end
      MODE_PLAY: begin
        plays_seen++;
        for (int v = 0; v < VOICES; v++) begin
          if (!voice_on[v]) begin
            voice_on[v] = 1'b1;
            v_start[v]  = rq.addr;
            v_len[v]    = rq.frames;
            v_pos[v]    = '0;
            v_gain[v]   = rq.gain;
            r.voice_id  = VID_W'(v);
            r.play_ok   = 1'b1;
            break;
          end
        end
        if (!r.play_ok) plays_refused++;
      end
      MODE_STOP: begin
        stops_seen++;
        if (int'(rq.sel) < VOICES) voice_on[rq.sel] = 1'b0;
      end
      default: begin
        renders_seen++;
        for (int v = 0; v < VOICES; v++) begin
          if (!voice_on[v]) continue;
          if (v_pos[v] >= v_len[v]) begin
            voice_on[v]   = 1'b0;
            r.finished[v] = 1'b1;
            continue;
          end
          for (int c = 0; c < CHANNELS; c++) begin
            a = 16'(v_start[v] + CHANNELS * v_pos[v] + c);
            if (int'(a) < SAMPLE_WORDS)
              acc[c & 1] += longint'(v_gain[v]) * longint'(sample_mem[a]);
          end
          v_pos[v] = v_pos[v] + 16'd1;
        end
        voices_ended += $countones(r.finished);
        r.left  = round_to_word(acc[0]);
        r.right = (CHANNELS > 1) ? round_to_word(acc[1]) : r.left;
      end
    endcase
    return r;
  endfunction

  function automatic mix_req_t random_fields();
    mix_req_t rq;
    rq.mode   = MODE_RENDER;
    rq.addr   = 16'($urandom);
    rq.sample = 16'($urandom);
    rq.frames = 16'($urandom_range(0, 32768));
    rq.gain   = 16'($urandom);
    rq.sel    = VID_W'($urandom);
    return rq;
  endfunction

  function automatic mix_req_t random_request();
    mix_req_t rq;
    int pick;
    int live[$];
    rq = random_fields();
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      rq.mode = MODE_LOAD;
      if ($urandom_range(0, 9) < 7) rq.addr = WINDOW_BASE + 16'($urandom_range(0, 1023));
      if ($urandom_range(0, 9) == 0) rq.sample = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
    end else if (pick < 55) begin
      rq.mode = MODE_PLAY;
      if ($urandom_range(0, 9) < 7) rq.addr = WINDOW_BASE + 16'($urandom_range(0, 1023));
      case ($urandom_range(0, 9))
        0:       rq.frames = 16'd32768;
        1:       rq.frames = 16'($urandom_range(0, 32768));
        2, 3:    rq.frames = 16'($urandom_range(13, 400));
        default: rq.frames = 16'($urandom_range(0, 12));
      endcase
      case ($urandom_range(0, 7))
        0:       rq.gain = 16'h0000;
        1:       rq.gain = 16'hffff;
        2, 3:    rq.gain = 16'd4096;
        default: ;
      endcase
    end else if (pick < 67) begin
      rq.mode = MODE_STOP;
      for (int v = 0; v < VOICES; v++)
        if (voice_on[v]) live.push_back(v);
      if (live.size() > 0 && $urandom_range(0, 3) != 0)
        rq.sel = VID_W'(live[$urandom_range(0, live.size() - 1)]);
    end
    return rq;
  endfunction

  task automatic drive_request(mix_req_t rq, bit typed, mix_res_t want);
    int gap;
    mix_res_t got;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 16);
    end
    start_i         <= 1'b1;
    mode_i          <= rq.mode;
    mem_address_i   <= rq.addr;
    sample_value_i  <= rq.sample;
    length_frames_i <= rq.frames;
    gain_i          <= rq.gain;
    voice_select_i  <= rq.sel;
    do @(posedge clk_i); while (busy_o);
    got = predict_mix(rq);
    pending_mix_results.push_back(typed ? want : got);
    burst_left--;
    requests_sent++;
  endtask

  // Load every word the next render will read that holds no sample yet.
  task automatic load_missing_words();
    mix_req_t ld;
    logic [15:0] a;
    for (int v = 0; v < VOICES; v++) begin
      for (int c = 0; c < CHANNELS; c++) begin
        a = 16'(v_start[v] + CHANNELS * v_pos[v] + c);
        if (voice_on[v] && v_pos[v] < v_len[v] && !word_loaded[a]) begin
          ld      = random_fields();
          ld.mode = MODE_LOAD;
          ld.addr = a;
          drive_request(ld, 1'b0, mk_res(0, 0, 0, 0, 0));
        end
      end
    end
  endtask

  task automatic send_request(mix_req_t rq, bit typed, mix_res_t want);
    if (rq.mode == MODE_RENDER) load_missing_words();
    drive_request(rq, typed, want);
  endtask

  initial begin
    script_row_t script[$];
    mix_req_t rq;
    rst_ni          = 1'b0;
    start_i         = 1'b0;
    mode_i          = MODE_LOAD;
    mem_address_i   = '0;
    sample_value_i  = '0;
    length_frames_i = '0;
    gain_i          = '0;
    voice_select_i  = '0;
    for (int v = 0; v < VOICES; v++) voice_on[v] = 1'b0;

    script.push_back('{mk_req(MODE_RENDER, 0, 0, 0, 0, 0), 1, 1'b1, mk_res(0, 0, 0, 0, 0)});
    script.push_back('{mk_req(MODE_STOP, 0, 0, 0, 0, 15), 1, 1'b1, mk_res(0, 0, 0, 0, 0)});
    script.push_back('{mk_req(MODE_LOAD, 0, 16'h7fff, 0, 0, 0), 1, 1'b1,
                       mk_res(0, 0, 0, 0, 0)});
    script.push_back('{mk_req(MODE_LOAD, 1, 16'h8000, 0, 0, 0), 1, 1'b1,
                       mk_res(0, 0, 0, 0, 0)});
    script.push_back('{mk_req(MODE_LOAD, 16'hffff, 16'hffff, 0, 0, 0), 1, 1'b1,
                       mk_res(0, 0, 0, 0, 0)});
    // exact half-LSB products to probe rounding direction
    script.push_back('{mk_req(MODE_LOAD, 2, 16'h0800, 0, 0, 0), 1, 1'b1,
                       mk_res(0, 0, 0, 0, 0)});
    script.push_back('{mk_req(MODE_LOAD, 3, 16'hf800, 0, 0, 0), 1, 1'b1,
                       mk_res(0, 0, 0, 0, 0)});
    script.push_back('{mk_req(MODE_PLAY, 0, 0, 1, 16'hffff, 0), 1, 1'b1,
                       mk_res(0, 1, 0, 0, 0)});
    script.push_back('{mk_req(MODE_RENDER, 0, 0, 0, 0, 0), 1, 1'b1,
                       mk_res(0, 0, 16'h7fff, 16'h8000, 0)});
    script.push_back('{mk_req(MODE_RENDER, 0, 0, 0, 0, 0), 1, 1'b1,
                       mk_res(0, 0, 0, 0, 16'h0001)});
    script.push_back('{mk_req(MODE_PLAY, 2, 0, 1, 1, 0), 1, 1'b1, mk_res(0, 1, 0, 0, 0)});
    script.push_back('{mk_req(MODE_RENDER, 0, 0, 0, 0, 0), 1, 1'b1, mk_res(0, 0, 1, 0, 0)});
    script.push_back('{mk_req(MODE_RENDER, 0, 0, 0, 0, 0), 1, 1'b1,
                       mk_res(0, 0, 0, 0, 16'h0001)});
    // zero-length voice ends on its first render
    script.push_back('{mk_req(MODE_PLAY, 0, 0, 0, 4096, 0), 1, 1'b1, mk_res(0, 1, 0, 0, 0)});
    script.push_back('{mk_req(MODE_RENDER, 0, 0, 0, 0, 0), 1, 1'b1,
                       mk_res(0, 0, 0, 0, 16'h0001)});
    // fill the pool with full-length voices, the first one wrapping the address
    script.push_back('{mk_req(MODE_PLAY, 16'hffff, 0, 16'd32768, 4096, 0), VOICES, 1'b0,
                       mk_res(0, 0, 0, 0, 0)});
    script.push_back('{mk_req(MODE_PLAY, 0, 0, 1, 4096, 0), 1, 1'b1, mk_res(0, 0, 0, 0, 0)});
    script.push_back('{mk_req(MODE_RENDER, 0, 0, 0, 0, 0), 1, 1'b0, mk_res(0, 0, 0, 0, 0)});
    script.push_back('{mk_req(MODE_STOP, 0, 0, 0, 0, 5), 1, 1'b1, mk_res(0, 0, 0, 0, 0)});
    script.push_back('{mk_req(MODE_STOP, 0, 0, 0, 0, 5), 1, 1'b1, mk_res(0, 0, 0, 0, 0)});
    script.push_back('{mk_req(MODE_PLAY, 0, 0, 1, 4096, 0), 1, 1'b1, mk_res(5, 1, 0, 0, 0)});
    script.push_back('{mk_req(MODE_RENDER, 0, 0, 0, 0, 0), 1, 1'b0, mk_res(0, 0, 0, 0, 0)});
    script.push_back('{mk_req(MODE_STOP, 0, 0, 0, 0, 0), VOICES, 1'b1,
                       mk_res(0, 0, 0, 0, 0)});
    script.push_back('{mk_req(MODE_RENDER, 0, 0, 0, 0, 0), 1, 1'b1, mk_res(0, 0, 0, 0, 0)});

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // repeated rows step the address and the voice select
    foreach (script[i]) begin
      for (int r = 0; r < script[i].reps; r++) begin
        rq      = script[i].req;
        rq.addr = 16'(rq.addr + r);
        rq.sel  = VID_W'(rq.sel + r);
        send_request(rq, script[i].typed, script[i].want);
      end
    end

    // sample loads ahead of a render count toward the total
    while (requests_sent < TOTAL_REQUESTS)
      send_request(random_request(), 1'b0, mk_res(0, 0, 0, 0, 0));

    start_i <= 1'b0;
    while (pending_mix_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d loads, %0d plays (%0d with the pool full), %0d stops, %0d renders.",
             loads_seen, plays_seen, plays_refused, stops_seen, renders_seen);
    $display("%0d results checked; %0d voices ran out, %0d mix samples clipped.",
             results_checked, voices_ended, clipped_samples);
    if (mismatches == 0 && pending_mix_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    mix_res_t want;
    if (rst_ni && done_o) begin
      if (pending_mix_results.size() == 0) begin
        $error("result strobe with no request outstanding");
        mismatches++;
      end else begin
        want = pending_mix_results.pop_front();
        results_checked++;
        if (voice_id_o !== want.voice_id) begin
          $error("voice_id: expected %0d, got %0d", want.voice_id, voice_id_o);
          mismatches++;
        end
        if (play_ok_o !== want.play_ok) begin
          $error("play_ok: expected %0d, got %0d", want.play_ok, play_ok_o);
          mismatches++;
        end
        if (mix_left_o !== want.left) begin
          $error("mix_left: expected %0d, got %0d", $signed(want.left), mix_left_o);
          mismatches++;
        end
        if (mix_right_o !== want.right) begin
          $error("mix_right: expected %0d, got %0d", $signed(want.right), mix_right_o);
          mismatches++;
        end
        if (finished_mask_o !== want.finished) begin
          $error("finished_mask: expected %h, got %h", want.finished, finished_mask_o);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $error("run stopped at the cycle limit, %0d results outstanding",
             pending_mix_results.size());
      $display("FAIL");
      $finish;
    end
  end

endmodule
